// ----- rtl/core/sscp_pkg.sv -----
// Shared types, widths and helpers for the segment closest-point pipeline.
package sscp_pkg;

	localparam int COORD_W = 32;          // input and output coordinate width
	localparam int DIFF_W  = COORD_W + 1; // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;  // one product of two differences
	localparam int DOT_W   = PROD_W + 2;  // sum of three products
	localparam int MUL_W   = 72;          // wide multiplier operand
	localparam int LIMB_W  = MUL_W / 3;   // partial-product limb
	localparam int MULP_W  = 2 * MUL_W;   // wide multiplier product
	localparam int DIV_W   = 136;         // divider operand width
	localparam int Q_FRAC  = 32;          // fraction bits of s and t
	localparam int Q_W     = Q_FRAC + 1;  // s and t in [0, 1]
	localparam int NUM_DOT = 5;

	// dot product slots
	localparam int D_AA = 0; // |dA|^2
	localparam int D_BB = 1; // |dB|^2
	localparam int D_BD = 2; // f = dB.(a_start - b_start)
	localparam int D_AD = 3; // c = dA.(a_start - b_start)
	localparam int D_AB = 4; // dA.dB

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [MUL_W-1:0]   mop_t;
	typedef logic signed [MULP_W-1:0]  mres_t;
	typedef logic signed [DIV_W-1:0]   divw_t;
	typedef logic [Q_W-1:0]            quo_t;

	localparam quo_t Q_ONE = quo_t'(1) << Q_FRAC;

	// per-beat data that rides along the pipeline
	typedef struct packed {
		coord_t [2:0] a_start;
		coord_t [2:0] b_start;
		diff_t  [2:0] a_dir;
		diff_t  [2:0] b_dir;
		dot_t         len_a;
		dot_t         len_b;
		dot_t         f;
		dot_t         c;
		dot_t         ab;
		logic         deg_a;
		logic         deg_b;
		quo_t         s;
		quo_t         t;
		logic         sel_s;  // second divide produces s, else t
	} item_t;

	function automatic mop_t dot_to_mop(dot_t x);
		return {{(MUL_W-DOT_W){x[DOT_W-1]}}, x};
	endfunction

	function automatic divw_t dot_to_div(dot_t x);
		return {{(DIV_W-DOT_W){x[DOT_W-1]}}, x};
	endfunction

endpackage

// ----- rtl/core/sscp_mul.sv -----
// Three-stage signed 72x72 multiplier built from 24x24 partial products.
module sscp_mul import sscp_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  mop_t  a,
	input  mop_t  b,
	output mres_t p
);

	logic              sign_s1;
	logic [MUL_W-1:0]  mag_a_s1;
	logic [MUL_W-1:0]  mag_b_s1;
	logic              sign_s2;
	logic [2*LIMB_W-1:0] pp_s2 [3][3];
	mres_t             p_s3;
	logic [MULP_W-1:0] acc;

	// stage 1: sign and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1  <= a[MUL_W-1] ^ b[MUL_W-1];
			mag_a_s1 <= a[MUL_W-1] ? $unsigned(-a) : $unsigned(a);
			mag_b_s1 <= b[MUL_W-1] ? $unsigned(-b) : $unsigned(b);
		end
	end

	// stage 2: limb products
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2 <= sign_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[i][j] <= mag_a_s1[LIMB_W*i +: LIMB_W] * mag_b_s1[LIMB_W*j +: LIMB_W];
				end
			end
		end
	end

	// stage 3: weighted sum, sign restore
	always_comb begin
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = acc + (MULP_W'(pp_s2[i][j]) << (LIMB_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= sign_s2 ? $signed(-acc) : $signed(acc);
		end
	end

	assign p = p_s3;

endmodule

// ----- rtl/core/sscp_div.sv -----
// Pipelined clamped divider: clamp(num/den, 0, 1) as Q1.32, one quotient bit per stage.
module sscp_div import sscp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  divw_t num,
	input  divw_t den,
	input  item_t in_item,
	output logic  out_valid,
	output quo_t  quo,
	output item_t out_item
);

	logic              vld_s  [Q_FRAC+1];
	logic              zero_s [Q_FRAC+1];
	logic              one_s  [Q_FRAC+1];
	logic [DIV_W-1:0]  rem_s  [Q_FRAC+1];
	logic [DIV_W-1:0]  den_s  [Q_FRAC+1];
	logic [Q_FRAC-1:0] q_s    [Q_FRAC+1];
	item_t             item_s [Q_FRAC+1];

	logic num_np, den_np;

	assign num_np = num[DIV_W-1] || (num == '0);
	assign den_np = den[DIV_W-1] || (den == '0);

	// entry stage: settle the clamped cases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= num_np || den_np;
			one_s[0]  <= num >= den;
			rem_s[0]  <= $unsigned(num);
			den_s[0]  <= $unsigned(den);
			q_s[0]    <= '0;
			item_s[0] <= in_item;
		end
	end

	// restoring steps
	for (genvar k = 1; k <= Q_FRAC; k++) begin : g_step
		logic [DIV_W:0] sh;
		logic [DIV_W:0] diff;
		logic           ge;

		assign sh   = {rem_s[k-1], 1'b0};
		assign diff = sh - {1'b0, den_s[k-1]};
		assign ge   = sh >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
				rem_s[k]  <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= {q_s[k-1][Q_FRAC-2:0], ge};
				item_s[k] <= item_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[Q_FRAC];
	assign out_item  = item_s[Q_FRAC];
	assign quo = zero_s[Q_FRAC] ? '0 :
	             one_s[Q_FRAC]  ? Q_ONE : {1'b0, q_s[Q_FRAC]};

endmodule

// ----- rtl/core/sscp_lerp.sv -----
// One output coordinate: start + dir*frac, rounded half up, saturated. Two stages.
module sscp_lerp import sscp_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  coord_t start,
	input  diff_t  dir,
	input  quo_t   frac,
	output coord_t near
);

	localparam int SUM_W = DIFF_W + Q_W + 2;
	localparam int SH_W  = SUM_W - Q_FRAC;

	localparam logic signed [SH_W-1:0] MAX_C = SH_W'({1'b0, {(COORD_W-1){1'b1}}});
	localparam logic signed [SH_W-1:0] MIN_C = -MAX_C - SH_W'(1);

	logic signed [DIFF_W+Q_W:0] prod_s1;
	coord_t                     start_s1;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SH_W-1:0]     sh;
	coord_t                     near_s2;

	// stage 1: scale direction
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= dir * $signed({1'b0, frac});
			start_s1 <= start;
		end
	end

	// stage 2: add start, round, saturate
	always_comb begin
		sum = (SUM_W'(start_s1) <<< Q_FRAC) + SUM_W'(prod_s1)
		      + (SUM_W'(1) <<< (Q_FRAC - 1));
		sh  = sum[SUM_W-1:Q_FRAC];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sh > MAX_C) begin
				near_s2 <= MAX_C[COORD_W-1:0];
			end else if (sh < MIN_C) begin
				near_s2 <= MIN_C[COORD_W-1:0];
			end else begin
				near_s2 <= sh[COORD_W-1:0];
			end
		end
	end

	assign near = near_s2;

endmodule

// ----- rtl/core/segment_segment_closest_points.sv -----
// Top level: closest points between two 3D segments, fully pipelined.
//
//  channel | signals                         | beat taken when
//  --------+---------------------------------+-------------------------
//  cfg     | cfg_we, cfg_wdata               | cfg_we high
//  in      | in_valid/in_ready, 12 coords    | in_valid && in_ready
//  out     | out_valid/out_ready, 6 coords   | out_valid && out_ready
//
// One beat per cycle unless the pipeline holds; it passes two 33-stage
// dividers (s, then t or re-solved s) and two 3-stage wide multipliers.
// Reset clears the valid bits and the threshold (0).
// The whole pipeline holds while out_valid is high and out_ready is low;
// in_ready is low exactly then.
module segment_segment_closest_points import sscp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  coord_t      a_start_x,
	input  coord_t      a_start_y,
	input  coord_t      a_start_z,
	input  coord_t      a_end_x,
	input  coord_t      a_end_y,
	input  coord_t      a_end_z,
	input  coord_t      b_start_x,
	input  coord_t      b_start_y,
	input  coord_t      b_start_z,
	input  coord_t      b_end_x,
	input  coord_t      b_end_y,
	input  coord_t      b_end_z,
	output logic        out_valid,
	input  logic        out_ready,
	output coord_t      near_a_x,
	output coord_t      near_a_y,
	output coord_t      near_a_z,
	output coord_t      near_b_x,
	output coord_t      near_b_y,
	output coord_t      near_b_z
);

	logic        en;
	logic [31:0] thr_q;

	coord_t a_s_in [3];
	coord_t a_e_in [3];
	coord_t b_s_in [3];
	coord_t b_e_in [3];

	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic   v_s8, v_s9, v_s10, v_s11, v_l1, v_out;
	coord_t a_start_s1 [3];
	coord_t b_start_s1 [3];
	diff_t  a_dir_s1 [3];
	diff_t  b_dir_s1 [3];
	diff_t  dd_s1 [3];
	coord_t a_start_s2 [3];
	coord_t b_start_s2 [3];
	diff_t  a_dir_s2 [3];
	diff_t  b_dir_s2 [3];
	prod_t  prod_s2 [NUM_DOT][3];
	dot_t   dot [NUM_DOT];
	item_t  item_d3;
	item_t  item_s3, item_s4, item_s5, item_s6, item_s7;
	item_t  item_s8, item_s9, item_s10, item_s11;
	item_t  item_d8;
	item_t  item_d11;
	mres_t  p_lab, p_ab2, p_abf, p_clb, p_abs;
	divw_t  denom_s7, snum_s7;
	divw_t  num1, num2_s11, den2_s11, num2_d, den2_d;
	logic   go1;
	logic   v_d1, v_d2;
	quo_t   q1, q2;
	item_t  item_q1, item_q2;
	mres_t  tnum, tden;
	quo_t   s_fin, t_fin;
	coord_t near [6];

	// global advance: hold everything while the output beat waits
	assign en       = !v_out || out_ready;
	assign in_ready = en;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign a_s_in = '{a_start_x, a_start_y, a_start_z};
	assign a_e_in = '{a_end_x, a_end_y, a_end_z};
	assign b_s_in = '{b_start_x, b_start_y, b_start_z};
	assign b_e_in = '{b_end_x, b_end_y, b_end_z};

	// valid chain outside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5  <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			v_l1  <= 1'b0; v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_d1;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_l1  <= v_d2;
			v_out <= v_l1;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_start_s1[k] <= a_s_in[k];
				b_start_s1[k] <= b_s_in[k];
				a_dir_s1[k]   <= DIFF_W'(a_e_in[k]) - DIFF_W'(a_s_in[k]);
				b_dir_s1[k]   <= DIFF_W'(b_e_in[k]) - DIFF_W'(b_s_in[k]);
				dd_s1[k]      <= DIFF_W'(a_s_in[k]) - DIFF_W'(b_s_in[k]);
			end
		end
	end

	// stage 2: component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_start_s2[k]    <= a_start_s1[k];
				b_start_s2[k]    <= b_start_s1[k];
				a_dir_s2[k]      <= a_dir_s1[k];
				b_dir_s2[k]      <= b_dir_s1[k];
				prod_s2[D_AA][k] <= a_dir_s1[k] * a_dir_s1[k];
				prod_s2[D_BB][k] <= b_dir_s1[k] * b_dir_s1[k];
				prod_s2[D_BD][k] <= b_dir_s1[k] * dd_s1[k];
				prod_s2[D_AD][k] <= a_dir_s1[k] * dd_s1[k];
				prod_s2[D_AB][k] <= a_dir_s1[k] * b_dir_s1[k];
			end
		end
	end

	// stage 3: dot sums and point tests
	always_comb begin
		for (int d = 0; d < NUM_DOT; d++) begin
			dot[d] = DOT_W'(prod_s2[d][0]) + DOT_W'(prod_s2[d][1]) + DOT_W'(prod_s2[d][2]);
		end
		item_d3 = '0;
		for (int k = 0; k < 3; k++) begin
			item_d3.a_start[k] = a_start_s2[k];
			item_d3.b_start[k] = b_start_s2[k];
			item_d3.a_dir[k]   = a_dir_s2[k];
			item_d3.b_dir[k]   = b_dir_s2[k];
		end
		item_d3.len_a = dot[D_AA];
		item_d3.len_b = dot[D_BB];
		item_d3.f     = dot[D_BD];
		item_d3.c     = dot[D_AD];
		item_d3.ab    = dot[D_AB];
		item_d3.deg_a = dot[D_AA] <= $signed({{(DOT_W-32){1'b0}}, thr_q});
		item_d3.deg_b = dot[D_BB] <= $signed({{(DOT_W-32){1'b0}}, thr_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_d3;
		end
	end

	// stages 4-6: wide products for the s numerator and denominator
	sscp_mul u_mul_lab (.clk, .en, .a(dot_to_mop(item_s3.len_a)),
		.b(dot_to_mop(item_s3.len_b)), .p(p_lab));
	sscp_mul u_mul_ab2 (.clk, .en, .a(dot_to_mop(item_s3.ab)),
		.b(dot_to_mop(item_s3.ab)), .p(p_ab2));
	sscp_mul u_mul_abf (.clk, .en, .a(dot_to_mop(item_s3.ab)),
		.b(dot_to_mop(item_s3.f)), .p(p_abf));
	sscp_mul u_mul_clb (.clk, .en, .a(dot_to_mop(item_s3.c)),
		.b(dot_to_mop(item_s3.len_b)), .p(p_clb));

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= item_s3;
			item_s5 <= item_s4;
			item_s6 <= item_s5;
		end
	end

	// stage 7: denominator and s numerator
	always_ff @(posedge clk) begin
		if (en) begin
			item_s7  <= item_s6;
			denom_s7 <= DIV_W'(p_lab - p_ab2);
			snum_s7  <= DIV_W'(p_abf - p_clb);
		end
	end

	// first divide only for two real, non-parallel segments; else s = 0
	assign go1  = !item_s7.deg_a && !item_s7.deg_b && (denom_s7 != '0);
	assign num1 = go1 ? snum_s7 : '0;

	sscp_div u_div_s (
		.clk, .arst_n, .en,
		.in_valid(v_s7), .num(num1), .den(denom_s7), .in_item(item_s7),
		.out_valid(v_d1), .quo(q1), .out_item(item_q1)
	);

	// stages 8-10: ab * s
	sscp_mul u_mul_abs (.clk, .en, .a(dot_to_mop(item_q1.ab)),
		.b(mop_t'({{(MUL_W-Q_W){1'b0}}, q1})), .p(p_abs));

	always_comb begin
		item_d8   = item_q1;
		item_d8.s = q1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s8  <= item_d8;
			item_s9  <= item_s8;
			item_s10 <= item_s9;
		end
	end

	// stage 11: t numerator, pick what the second divide solves
	assign tnum = p_abs + (MULP_W'(item_s10.f) <<< Q_FRAC);
	assign tden = MULP_W'(item_s10.len_b) <<< Q_FRAC;

	always_comb begin
		item_d11       = item_s10;
		item_d11.sel_s = 1'b0;
		item_d11.t     = '0;
		num2_d         = '0;
		den2_d         = '0;
		if (item_s10.deg_a && item_s10.deg_b) begin
			item_d11.s = '0;
		end else if (item_s10.deg_a) begin
			item_d11.s = '0;
			num2_d     = dot_to_div(item_s10.f);
			den2_d     = dot_to_div(item_s10.len_b);
		end else if (item_s10.deg_b) begin
			item_d11.sel_s = 1'b1;
			num2_d         = dot_to_div(-item_s10.c);
			den2_d         = dot_to_div(item_s10.len_a);
		end else if (tnum[MULP_W-1]) begin
			// t below range
			item_d11.sel_s = 1'b1;
			num2_d         = dot_to_div(-item_s10.c);
			den2_d         = dot_to_div(item_s10.len_a);
		end else if (tnum > tden) begin
			// t above range
			item_d11.sel_s = 1'b1;
			item_d11.t     = Q_ONE;
			num2_d         = dot_to_div(item_s10.ab - item_s10.c);
			den2_d         = dot_to_div(item_s10.len_a);
		end else begin
			num2_d = DIV_W'(tnum);
			den2_d = DIV_W'(tden);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s11 <= item_d11;
			num2_s11 <= num2_d;
			den2_s11 <= den2_d;
		end
	end

	sscp_div u_div_t (
		.clk, .arst_n, .en,
		.in_valid(v_s11), .num(num2_s11), .den(den2_s11), .in_item(item_s11),
		.out_valid(v_d2), .quo(q2), .out_item(item_q2)
	);

	assign s_fin = item_q2.sel_s ? q2 : item_q2.s;
	assign t_fin = item_q2.sel_s ? item_q2.t : q2;

	// output lanes
	for (genvar k = 0; k < 3; k++) begin : g_lane
		sscp_lerp u_lerp_a (.clk, .en, .start(item_q2.a_start[k]),
			.dir(item_q2.a_dir[k]), .frac(s_fin), .near(near[k]));
		sscp_lerp u_lerp_b (.clk, .en, .start(item_q2.b_start[k]),
			.dir(item_q2.b_dir[k]), .frac(t_fin), .near(near[3+k]));
	end

	assign out_valid = v_out;
	assign near_a_x  = near[0];
	assign near_a_y  = near[1];
	assign near_a_z  = near[2];
	assign near_b_x  = near[3];
	assign near_b_y  = near[4];
	assign near_b_z  = near[5];

endmodule
